FILE: sv/mwm_pkg.sv
// Types and constants shared by the mecanum wheel mixer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mwm_pkg;

  localparam int ArmFracBits = 12;
  localparam int NumWheels   = 4;
  localparam int SpeedW      = 18;  // wheel speed, signed
  localparam int MagW        = 17;  // wheel magnitude, unsigned
  localparam int ProdW       = 29;  // arm_length * yaw_rate
  localparam int DivSteps    = 17;  // one quotient bit per stage

  typedef enum logic [2:0] {
    RegArmLength     = 3'd0,
    RegInvertMask    = 3'd1,
    RegDeadband      = 3'd2,
    RegStopLinEps    = 3'd3,
    RegStopAngEps    = 3'd4,
    RegMaxWheelSpeed = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                                 v;
    logic                                 stop;
    logic                                 scl;
    logic [NumWheels-1:0][SpeedW-1:0]     w;
    logic [MagW-1:0]                      d;   // divisor: largest magnitude
  } pipe_t;

  function automatic logic [MagW-1:0] mag_speed(logic signed [SpeedW-1:0] v);
    logic signed [SpeedW-1:0] n;
    n = -v;
    return (v < 0) ? MagW'(n) : MagW'(v);
  endfunction

  function automatic logic [16:0] mag_in(logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    return (e < 0) ? 17'(-e) : 17'(e);
  endfunction

endpackage
`default_nettype wire

FILE: sv/mecanum_wheel_mixer_top.sv
// Mecanum wheel mixer top level: inverse kinematics, deadband, stop and
// proportional desaturation. Depends on mwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
// A body velocity command beat (forward, left, yaw rate, Q3.12) goes in on
// the s_axis side and one beat of four wheel speeds plus stopped/scaled flags
// comes out on the m_axis side. The pipeline takes one beat per clock while
// the output is not stalled. It is built from six stages of mixing, deadband,
// largest-magnitude search and the 17x17 scaling multiply, then a 17-stage
// restoring divider (one quotient bit per stage) that forms |w|*limit/max,
// then the output register. The whole pipeline advances together; it holds
// while an output beat waits, so s_axis_tready follows m_axis_tready
// whenever the output register is full.
// Configuration goes through the APB port at byte address 4*index and must
// only be written while no command is in flight.
module mecanum_wheel_mixer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // vel_forward, vel_left, yaw_rate
  // master stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,   // front_left, front_right, rear_left, rear_right
  output logic [1:0]       m_axis_tuser_o,   // stopped, scaled
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mwm_pkg::*;

  // ---------------- configuration registers ----------------
  logic [11:0] arm_q;
  logic [3:0]  mask_q;
  logic [14:0] db_q, lin_eps_q, ang_eps_q;
  logic [16:0] lim_q;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q     <= 12'd819;
      mask_q    <= 4'd0;
      db_q      <= 15'd41;
      lin_eps_q <= 15'd20;
      ang_eps_q <= 15'd20;
      lim_q     <= 17'd8192;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        RegArmLength:     arm_q     <= pwdata[11:0];
        RegInvertMask:    mask_q    <= pwdata[3:0];
        RegDeadband:      db_q      <= pwdata[14:0];
        RegStopLinEps:    lin_eps_q <= pwdata[14:0];
        RegStopAngEps:    ang_eps_q <= pwdata[14:0];
        RegMaxWheelSpeed: lim_q     <= pwdata[16:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      RegArmLength:     prdata = {20'd0, arm_q};
      RegInvertMask:    prdata = {28'd0, mask_q};
      RegDeadband:      prdata = {17'd0, db_q};
      RegStopLinEps:    prdata = {17'd0, lin_eps_q};
      RegStopAngEps:    prdata = {17'd0, ang_eps_q};
      RegMaxWheelSpeed: prdata = {15'd0, lim_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic out_v_q;
  logic adv;  // every stage moves when the output register can take a beat

  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // ---------------- stage 1: arm product, stop check ----------------
  logic signed [15:0] in_vf, in_vl, in_wz;
  logic signed [ProdW-1:0] arm_ext, wz_ext;
  logic in_stop;

  assign in_vf   = s_axis_tdata_i[15:0];
  assign in_vl   = s_axis_tdata_i[31:16];
  assign in_wz   = s_axis_tdata_i[47:32];
  assign arm_ext = ProdW'($signed({1'b0, arm_q}));
  assign wz_ext  = ProdW'(in_wz);
  assign in_stop = (mag_in(in_vf) < {2'b0, lin_eps_q}) &&
                   (mag_in(in_vl) < {2'b0, lin_eps_q}) &&
                   (mag_in(in_wz) < {2'b0, ang_eps_q});

  logic                    v1_q, stop1_q;
  logic signed [15:0]      vf1_q, vl1_q;
  logic signed [ProdW-1:0] prod1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= s_axis_tvalid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      stop1_q <= in_stop;
      vf1_q   <= in_vf;
      vl1_q   <= in_vl;
      prod1_q <= arm_ext * wz_ext;
    end
  end

  // ---------------- stage 2: wheel sums, polarity ----------------
  logic signed [16:0] lw;
  logic signed [18:0] vf19, vl19, lw19;
  logic signed [18:0] sum [NumWheels];
  pipe_t p2_d, p2_q;

  assign lw   = 17'(prod1_q >>> ArmFracBits);  // floor shift
  assign vf19 = 19'(vf1_q);
  assign vl19 = 19'(vl1_q);
  assign lw19 = 19'(lw);
  assign sum[0] =  vf19 - vl19 - lw19;
  assign sum[1] =  vf19 + vl19 + lw19;
  assign sum[2] = -vf19 - vl19 + lw19;
  assign sum[3] = -vf19 + vl19 - lw19;

  always_comb begin
    p2_d      = '0;
    p2_d.v    = v1_q;
    p2_d.stop = stop1_q;
    for (int i = 0; i < NumWheels; i++) begin
      p2_d.w[i] = mask_q[i] ? SpeedW'(-sum[i]) : SpeedW'(sum[i]);
    end
  end

  // ---------------- stage 3: deadband ----------------
  pipe_t p3_d, p3_q;
  logic [MagW-1:0] mag3_d [NumWheels];
  logic [MagW-1:0] mag3_q [NumWheels];

  always_comb begin
    p3_d = p2_q;
    for (int i = 0; i < NumWheels; i++) begin
      mag3_d[i] = mag_speed(p2_q.w[i]);
      if (mag3_d[i] < {2'b0, db_q}) begin
        p3_d.w[i] = '0;
        mag3_d[i] = '0;
      end
    end
  end

  // ---------------- stage 4: pairwise max ----------------
  logic [MagW-1:0] mx4_q [2];
  logic [MagW-1:0] mag4_q [NumWheels];
  pipe_t p4_q;

  // ---------------- stage 5: overall max, limit compare ----------------
  pipe_t p5_d, p5_q;
  logic [MagW-1:0] mag5_q [NumWheels];
  logic [MagW-1:0] mx5;

  assign mx5 = (mx4_q[0] > mx4_q[1]) ? mx4_q[0] : mx4_q[1];

  always_comb begin
    p5_d     = p4_q;
    p5_d.d   = mx5;
    p5_d.scl = !p4_q.stop && (mx5 > lim_q);
    if (p4_q.stop) p5_d.w = '0;
  end

  // ---------------- divider stages ----------------
  // Stage 0 takes N = |w|*limit; N < max<<17, so the top 17 bits start as
  // the partial remainder and each stage shifts in one more dividend bit.
  pipe_t           pd_q  [DivSteps+1];
  logic [MagW-1:0] rem_q [DivSteps+1][NumWheels];
  logic [MagW-1:0] lo_q  [DivSteps+1][NumWheels];
  logic [MagW-1:0] quo_q [DivSteps+1][NumWheels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_q <= '0;
      p3_q <= '0;
      p4_q <= '0;
      p5_q <= '0;
    end else if (adv) begin
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p3_q;
      p5_q <= p5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [2*MagW-1:0] n;
    if (adv) begin
      mx4_q[0] <= (mag3_q[0] > mag3_q[1]) ? mag3_q[0] : mag3_q[1];
      mx4_q[1] <= (mag3_q[2] > mag3_q[3]) ? mag3_q[2] : mag3_q[3];
      for (int i = 0; i < NumWheels; i++) begin
        mag3_q[i] <= mag3_d[i];
        mag4_q[i] <= mag3_q[i];
        mag5_q[i] <= mag4_q[i];
        n = mag5_q[i] * lim_q;
        rem_q[0][i] <= n[2*MagW-1:MagW];
        lo_q[0][i]  <= n[MagW-1:0];
        quo_q[0][i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pd_q[0] <= '0;
    else if (adv) pd_q[0] <= p5_q;
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_div
    logic [MagW:0]   t   [NumWheels];
    logic            ge  [NumWheels];
    logic [MagW:0]   dif [NumWheels];

    always_comb begin
      for (int i = 0; i < NumWheels; i++) begin
        t[i]   = {rem_q[k-1][i], lo_q[k-1][i][MagW-1]};
        ge[i]  = t[i] >= {1'b0, pd_q[k-1].d};
        dif[i] = t[i] - {1'b0, pd_q[k-1].d};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) pd_q[k] <= '0;
      else if (adv) pd_q[k] <= pd_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < NumWheels; i++) begin
          rem_q[k][i] <= ge[i] ? dif[i][MagW-1:0] : t[i][MagW-1:0];
          lo_q[k][i]  <= {lo_q[k-1][i][MagW-2:0], 1'b0};
          quo_q[k][i] <= {quo_q[k-1][i][MagW-2:0], ge[i]};
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic [NumWheels-1:0][SpeedW-1:0] spd_d, spd_q;
  logic stop_o_q, scl_o_q;

  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      if (pd_q[DivSteps].scl) begin
        spd_d[i] = pd_q[DivSteps].w[i][SpeedW-1]
                   ? -SpeedW'(quo_q[DivSteps][i]) : SpeedW'(quo_q[DivSteps][i]);
      end else begin
        spd_d[i] = pd_q[DivSteps].w[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= pd_q[DivSteps].v;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spd_q    <= spd_d;
      stop_o_q <= pd_q[DivSteps].stop;
      scl_o_q  <= pd_q[DivSteps].scl;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = spd_q;
  assign m_axis_tuser_o  = {scl_o_q, stop_o_q};

  // ---------------- assertions ----------------
  logic [NumWheels-1:0] within_lim;
  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      within_lim[i] = mag_speed(spd_q[i]) <= lim_q;
    end
  end

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && stop_o_q) |-> (spd_q == '0))
    else $error("stopped beat with nonzero wheel speed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(stop_o_q && scl_o_q))
    else $error("stopped and scaled both set");

  a_scaled_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && scl_o_q) |-> (within_lim == '1))
    else $error("scaled wheel exceeds limit");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready_i) |=> (out_v_q && $stable(spd_q)))
    else $error("stalled output changed");

endmodule
`default_nettype wire

FILE: test/mecanum_wheel_mixer_top_test.sv
// Self-checking testbench for mecanum_wheel_mixer_top: APB register setup,
// directed and random velocity commands, wheel-speed predictor. Uses mwm_pkg.
`timescale 1ns / 1ps
module mecanum_wheel_mixer_top_test;
  import mwm_pkg::*;

  localparam int Latency = 24;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [17:0] fl, fr, rl, rr;
    logic        stopped, scaled;
  } wheels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mecanum_wheel_mixer_top dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // shadow registers
  logic [11:0] arm_q = 12'd819;
  logic [3:0]  inv_q = 4'd0;
  logic [14:0] db_q = 15'd41, lin_q = 15'd20, ang_q = 15'd20;
  logic [16:0] lim_q = 17'd8192;

  wheels_t expected_wheels[$];
  int      errors = 0;
  int      send_idle_pct = 6, recv_idle_pct = 69;
  bit      recv_hold = 0;
  longint  cycles = 0;

  function automatic wheels_t mix_wheels(logic [47:0] cmd);
    longint vf, vl, wz, lw, mx, q;
    longint w[4];
    wheels_t r;
    vf = longint'($signed(cmd[15:0]));
    vl = longint'($signed(cmd[31:16]));
    wz = longint'($signed(cmd[47:32]));
    lw = (longint'(arm_q) * wz) >>> ArmFracBits;
    r = '0;
    r.stopped = (vf < 0 ? -vf : vf) < lin_q && (vl < 0 ? -vl : vl) < lin_q &&
                (wz < 0 ? -wz : wz) < ang_q;
    w[0] = vf - vl - lw;
    w[1] = vf + vl + lw;
    w[2] = -(vf + vl - lw);
    w[3] = -(vf - vl + lw);
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      if (inv_q[i]) w[i] = -w[i];
      if ((w[i] < 0 ? -w[i] : w[i]) < db_q) w[i] = 0;
      if ((w[i] < 0 ? -w[i] : w[i]) > mx) mx = w[i] < 0 ? -w[i] : w[i];
    end
    if (r.stopped) begin
      for (int i = 0; i < 4; i++) w[i] = 0;
    end else if (mx > lim_q) begin
      r.scaled = 1'b1;
      for (int i = 0; i < 4; i++) begin
        q = ((w[i] < 0 ? -w[i] : w[i]) * longint'(lim_q)) / mx;
        w[i] = w[i] < 0 ? -q : q;
      end
    end
    r.fl = w[0][17:0]; r.fr = w[1][17:0]; r.rl = w[2][17:0]; r.rr = w[3][17:0];
    return r;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(4 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegArmLength:     arm_q = val[11:0];
      RegInvertMask:    inv_q = val[3:0];
      RegDeadband:      db_q  = val[14:0];
      RegStopLinEps:    lin_q = val[14:0];
      RegStopAngEps:    ang_q = val[14:0];
      RegMaxWheelSpeed: lim_q = val[16:0];
      default: ;
    endcase
  endtask

  // wait for the pipeline to empty before touching registers
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_wheels.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic set_all(logic [11:0] a, logic [3:0] m, logic [14:0] d,
                         logic [14:0] l, logic [14:0] g, logic [16:0] s);
    drain();
    apb_write(RegArmLength, 32'(a));
    apb_write(RegInvertMask, 32'(m));
    apb_write(RegDeadband, 32'(d));
    apb_write(RegStopLinEps, 32'(l));
    apb_write(RegStopAngEps, 32'(g));
    apb_write(RegMaxWheelSpeed, 32'(s));
  endtask

  // one command beat; predictor runs when the beat is accepted.
  // tvalid stays high afterwards until the next beat or an explicit idle.
  task automatic send_cmd(logic [47:0] cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_wheels.push_back(mix_wheels(cmd));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rnd_vel();
    case ($urandom_range(5))
      0: return 16'($urandom_range(40)) - 16'd20;
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      2: return 16'($urandom_range(8000)) - 16'd4000;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, sampled at the rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_wheels.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        wheels_t e;
        e = expected_wheels.pop_front();
        if (m_axis_tdata_o[17:0] !== e.fl) begin
          $error("front_left_speed exp %h got %h", e.fl, m_axis_tdata_o[17:0]); errors++;
        end
        if (m_axis_tdata_o[35:18] !== e.fr) begin
          $error("front_right_speed exp %h got %h", e.fr, m_axis_tdata_o[35:18]); errors++;
        end
        if (m_axis_tdata_o[53:36] !== e.rl) begin
          $error("rear_left_speed exp %h got %h", e.rl, m_axis_tdata_o[53:36]); errors++;
        end
        if (m_axis_tdata_o[71:54] !== e.rr) begin
          $error("rear_right_speed exp %h got %h", e.rr, m_axis_tdata_o[71:54]); errors++;
        end
        if (m_axis_tuser_o[0] !== e.stopped) begin
          $error("stopped exp %b got %b", e.stopped, m_axis_tuser_o[0]); errors++;
        end
        if (m_axis_tuser_o[1] !== e.scaled) begin
          $error("scaled exp %b got %b", e.scaled, m_axis_tuser_o[1]); errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // directed rows: {yaw, left, forward}; flags given where obvious
  typedef struct {
    logic [47:0] cmd;
    bit          known;
    wheels_t     res;
  } row_t;
  row_t rows[$];

  initial begin
    rows.push_back('{48'h0, 1, '{0, 0, 0, 0, 1, 0}});
    rows.push_back('{{16'd19, 16'hffed, 16'd19}, 1, '{0, 0, 0, 0, 1, 0}});
    rows.push_back('{{16'd20, 16'd0, 16'd0}, 0, '0});
    rows.push_back('{{16'd0, 16'd0, 16'd20}, 0, '0});
    rows.push_back('{{16'd0, 16'd20, 16'd0}, 0, '0});
    rows.push_back('{{16'd0, 16'd0, 16'd40}, 0, '0});
    rows.push_back('{{16'd0, 16'd0, 16'd41}, 0, '0});
    rows.push_back('{{16'd0, 16'd0, 16'h7fff}, 0, '0});
    rows.push_back('{{16'd0, 16'd0, 16'h8000}, 0, '0});
    rows.push_back('{{16'd0, 16'h7fff, 16'd0}, 0, '0});
    rows.push_back('{{16'd0, 16'h8000, 16'd0}, 0, '0});
    rows.push_back('{{16'h7fff, 16'd0, 16'd0}, 0, '0});
    rows.push_back('{{16'h8000, 16'd0, 16'd0}, 0, '0});
    rows.push_back('{{16'h8000, 16'h8000, 16'h8000}, 0, '0});
    rows.push_back('{{16'h7fff, 16'h7fff, 16'h7fff}, 0, '0});
    rows.push_back('{{16'h8000, 16'h7fff, 16'h7fff}, 0, '0});
    rows.push_back('{{16'hffff, 16'hffff, 16'h1000}, 0, '0});
    rows.push_back('{{16'd1000, 16'd2000, 16'd3000}, 0, '0});

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase A: reset settings, directed table
    foreach (rows[i]) begin
      if (rows[i].known) begin
        if (mix_wheels(rows[i].cmd) !== rows[i].res) begin
          $error("directed row %0d table mismatch", i);
          errors++;
        end
      end
      send_cmd(rows[i].cmd);
    end

    // random phases across register settings, idle profiles
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        1: set_all(12'd0, 4'hf, 15'd0, 15'd0, 15'd0, 17'd1);
        2: set_all(12'hfff, 4'h5, 15'h7fff, 15'h7fff, 15'h7fff, 17'h1ffff);
        3: begin
          set_all(12'($urandom), 4'($urandom), 15'($urandom_range(200)),
                  15'($urandom_range(100)), 15'($urandom_range(100)),
                  17'($urandom_range(20000, 1)));
          send_idle_pct = 69; recv_idle_pct = 6;
        end
        4: set_all(12'd2048, 4'ha, 15'd100, 15'd50, 15'd50, 17'd4096);
        5: set_all(12'($urandom), 4'($urandom), 15'($urandom),
                   15'($urandom), 15'($urandom), 17'($urandom_range(131071, 1)));
        6: begin
          set_all(12'd819, 4'h3, 15'd41, 15'd20, 15'd20, 17'd8192);
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        7: set_all(12'($urandom), 4'($urandom), 15'($urandom_range(500)),
                   15'($urandom_range(50)), 15'($urandom_range(50)),
                   17'($urandom_range(131071, 1)));
        8: set_all(12'd819, 4'h0, 15'd41, 15'd20, 15'd20, 17'd8192);
        default: ;
      endcase
      for (int n = 0; n < 190; n++) begin
        // long receiver hold-off so the pipeline backs up
        if (ph == 6 && n == 20) fork
          begin
            recv_hold = 1;
            repeat (80) @(negedge clk_i);
            recv_hold = 0;
          end
        join_none
        // sender waits for everything outstanding
        if (ph == 7 && n == 95) begin
          s_axis_tvalid_i <= 1'b0;
          while (expected_wheels.size() != 0) @(negedge clk_i);
        end
        send_cmd({rnd_vel(), rnd_vel(), rnd_vel()});
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (expected_wheels.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
